FILE: rtl/ascdf_pkg.sv
// ----------------------------------------------------------------------------
// ascdf_pkg
// Shared types and constants for the ASCII decimal field adder.
// ----------------------------------------------------------------------------
package ascdf_pkg;

   localparam int MAX_LEN_DEF = 16;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [3:0] RADIX      = 4'd10;

   // Reciprocal of ten, exact for every 16-bit magnitude after a shift by 19
   localparam logic [15:0] RECIP_TEN = 16'hCCCD;
   localparam int          RECIP_SH  = 19;

   typedef struct packed {
      logic [7:0]         char_in;
      logic signed [15:0] addend;
      logic               char_last;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       field_ok;
      logic       out_last;
   } rsp_type;

endpackage

FILE: rtl/ascii_decimal_field_add.sv
// ----------------------------------------------------------------------------
// ascii_decimal_field_add
// Collects an ASCII decimal field one character per item, adds a signed
// value to it digit by digit from the right and streams the field back.
// ----------------------------------------------------------------------------
// A non-final item is stored while idle. A final item walks each
// touched digit (store read, then write back), 1 to MAX_LEN digits, none for
// an invalid field; results then follow one per cycle, the first after the
// emit state and the strobe register. Items are refused while busy, which
// is high through the walk and the emit. Results cannot be stalled. Synchronous
// reset empties the field and returns to idle; store contents are not cleared.
module ascii_decimal_field_add #(
   parameter int MAX_LEN = ascdf_pkg::MAX_LEN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ascdf_pkg::req_type req_item,
   output logic               rsp_strobe,
   output ascdf_pkg::rsp_type rsp_item
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LW = $clog2(MAX_LEN + 1);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_WALK_RD = 4'b0010,
      ST_WALK_WR = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [LW-1:0] length_ff, length_in;
   logic        seen_ff, seen_in;
   logic        bad_ff, bad_in;
   logic        ok_ff, ok_in;
   logic        neg_ff, neg_in;
   logic [15:0] mag_ff, mag_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic        pend_ff, pend_in;
   logic        pend_last_ff, pend_last_in;
   logic        pend_ok_ff, pend_ok_in;

   logic        accept;
   logic        has_room;
   logic        is_digit;
   logic        seen_nx;
   logic        bad_nx;
   logic [LW-1:0] length_nx;
   logic [15:0] add_mag;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]  wr_data;
   logic [AW-1:0] rd_addr;
   logic [7:0]  rd_data;
   logic [7:0]  step_char;
   logic [15:0] step_mag;
   logic        emit_end;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   ascdf_store #(
      .MAX_LEN (MAX_LEN),
      .AW      (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ascdf_digit u_digit (
      .neg      (neg_ff),
      .mag      (mag_ff),
      .char_in  (rd_data),
      .char_out (step_char),
      .mag_next (step_mag)
   );

   always_comb begin
      has_room  = (length_ff < LW'(MAX_LEN));
      is_digit  = (req_item.char_in >= ascdf_pkg::CHAR_ZERO) &&
                  (req_item.char_in <= ascdf_pkg::CHAR_NINE);
      seen_nx   = seen_ff;
      bad_nx    = bad_ff;
      length_nx = length_ff;
      if (has_room) begin
         length_nx = length_ff + LW'(1);
         if (req_item.char_in == ascdf_pkg::CHAR_SPACE) begin
            if (seen_ff) begin
               bad_nx = 1'b1;
            end
         end else begin
            seen_nx = 1'b1;
            if (!is_digit) begin
               bad_nx = 1'b1;
            end
         end
      end else begin
         bad_nx = 1'b1;
      end
      add_mag  = req_item.addend[15] ? 16'(~req_item.addend + 16'sd1)
                                     : 16'(req_item.addend);
      emit_end = ((LW'(pos_ff) + LW'(1)) == length_ff);
   end

   always_comb begin
      state_in     = state_ff;
      length_in    = length_ff;
      seen_in      = seen_ff;
      bad_in       = bad_ff;
      ok_in        = ok_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      pos_in       = pos_ff;
      pend_in      = 1'b0;
      pend_last_in = pend_last_ff;
      pend_ok_in   = pend_ok_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = step_char;
      rd_addr      = pos_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wr_en   = has_room;
               wr_addr = length_ff[AW-1:0];
               wr_data = req_item.char_in;
               length_in = length_nx;
               if (req_item.char_last) begin
                  ok_in   = !bad_nx && seen_nx;
                  seen_in = 1'b0;
                  bad_in  = 1'b0;
                  neg_in  = req_item.addend[15];
                  mag_in  = add_mag;
                  if (!bad_nx && seen_nx) begin
                     pos_in   = AW'(length_nx - LW'(1));
                     state_in = ST_WALK_RD;
                  end else begin
                     pos_in   = '0;
                     state_in = ST_EMIT;
                  end
               end else begin
                  seen_in = seen_nx;
                  bad_in  = bad_nx;
               end
            end
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_WR;
         end
         ST_WALK_WR: begin
            wr_en  = 1'b1;
            mag_in = step_mag;
            // stop once nothing carries on, or at the left end
            if (step_mag == 16'd0 || pos_ff == '0) begin
               pos_in   = '0;
               state_in = ST_EMIT;
            end else begin
               pos_in   = pos_ff - AW'(1);
               state_in = ST_WALK_RD;
            end
         end
         ST_EMIT: begin
            pend_in      = 1'b1;
            pend_last_in = emit_end;
            pend_ok_in   = ok_ff;
            if (emit_end) begin
               length_in = '0;
               state_in  = ST_IDLE;
            end else begin
               pos_in = pos_ff + AW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         length_ff <= '0;
         seen_ff   <= 1'b0;
         bad_ff    <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         length_ff <= length_in;
         seen_ff   <= seen_in;
         bad_ff    <= bad_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff        <= ok_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      pos_ff       <= pos_in;
      pend_last_ff <= pend_last_in;
      pend_ok_ff   <= pend_ok_in;
   end

   assign rsp_strobe        = pend_ff;
   assign rsp_item.char_out = rd_data;
   assign rsp_item.field_ok = pend_ok_ff;
   assign rsp_item.out_last = pend_last_ff;

`ifndef SYNTHESIS
   a_emit_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.out_last |=> rsp_strobe)
      else $error("result stream broke before its final item");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.out_last |=> !rsp_strobe)
      else $error("result after the final item of a field");

   a_busy_after_close: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.char_last |=> busy)
      else $error("closing item did not start the walk or emit");

   a_quiet_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_RD || state_ff == ST_WALK_WR) |-> !rsp_strobe)
      else $error("result strobe during the digit walk");
`endif

endmodule

FILE: rtl/ascdf_store.sv
// ----------------------------------------------------------------------------
// ascdf_store
// Character store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module ascdf_store #(
   parameter int MAX_LEN = ascdf_pkg::MAX_LEN_DEF,
   parameter int AW      = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [MAX_LEN];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ascdf_digit.sv
// ----------------------------------------------------------------------------
// ascdf_digit
// One decimal digit step: adds or subtracts the low digit of the remaining
// magnitude to one character and returns the carried-on magnitude.
// ----------------------------------------------------------------------------
module ascdf_digit (
   input  logic        neg,
   input  logic [15:0] mag,
   input  logic [7:0]  char_in,
   output logic [7:0]  char_out,
   output logic [15:0] mag_next
);

   logic [31:0] prod;
   logic [15:0] quot;
   logic [15:0] quot_x10;
   logic [3:0]  rem;
   logic [3:0]  dig;
   logic [4:0]  sum;
   logic        cy;
   logic [3:0]  res;

   always_comb begin
      prod     = mag * ascdf_pkg::RECIP_TEN;
      quot     = 16'(prod >> ascdf_pkg::RECIP_SH);
      quot_x10 = 16'((quot << 3) + (quot << 1));
      rem      = 4'(mag - quot_x10);
      // a space counts as zero
      dig      = (char_in == ascdf_pkg::CHAR_SPACE) ? 4'd0 : char_in[3:0];
      if (!neg) begin
         sum = {1'b0, dig} + {1'b0, rem};
         cy  = (sum > {1'b0, ascdf_pkg::RADIX - 4'd1});
         res = cy ? 4'(sum - {1'b0, ascdf_pkg::RADIX}) : sum[3:0];
      end else begin
         sum = {1'b0, dig} - {1'b0, rem};
         cy  = (dig < rem);
         res = cy ? 4'(dig + ascdf_pkg::RADIX - rem) : sum[3:0];
      end
      char_out = ascdf_pkg::CHAR_ZERO | {4'd0, res};
      mag_next = quot + {15'd0, cy};
   end

endmodule
